// File: design/u8dhc_pkg.sv
// UTF-8 decoder package: widths, byte and code point limits, result type, Han ranges.
package u8dhc_pkg;

    // Widths of the stream payloads
    localparam int ByteW     = 8;
    localparam int CpW       = 21;
    localparam int LenW      = 3;
    localparam int InDataW   = 8;
    localparam int OutDataW  = 24;
    localparam int OutUserW  = 2;

    // Lead byte boundaries
    localparam logic [ByteW-1:0] LeadAsciiMax = 8'h7F;
    localparam logic [ByteW-1:0] Lead2Min     = 8'hC2;
    localparam logic [ByteW-1:0] Lead2Max     = 8'hDF;
    localparam logic [ByteW-1:0] Lead3Min     = 8'hE0;
    localparam logic [ByteW-1:0] Lead3Max     = 8'hEF;
    localparam logic [ByteW-1:0] Lead4Min     = 8'hF0;
    localparam logic [ByteW-1:0] Lead4Max     = 8'hF4;
    localparam logic [1:0]       ContTag      = 2'b10;

    // Sequence lengths
    localparam logic [LenW-1:0] Len1 = 3'd1;
    localparam logic [LenW-1:0] Len2 = 3'd2;
    localparam logic [LenW-1:0] Len3 = 3'd3;
    localparam logic [LenW-1:0] Len4 = 3'd4;

    // Scalar value limits
    localparam logic [CpW-1:0] Min3Byte  = 21'h000800;
    localparam logic [CpW-1:0] Min4Byte  = 21'h010000;
    localparam logic [CpW-1:0] SurrLo    = 21'h00D800;
    localparam logic [CpW-1:0] SurrHi    = 21'h00DFFF;
    localparam logic [CpW-1:0] MaxScalar = 21'h10FFFF;

    // One decoded result
    typedef struct packed {
        logic [CpW-1:0]  code_point;
        logic [LenW-1:0] seq_length;
        logic            decode_error;
        logic            is_han;
        logic            text_done;
    } res_t;

    // Han ideograph ranges
    function automatic logic han_range(input logic [CpW-1:0] cp);
        han_range = (cp == 21'h003007) ||
                    (cp >= 21'h003400 && cp <= 21'h004DBF) ||
                    (cp >= 21'h004E00 && cp <= 21'h009FFF) ||
                    (cp >= 21'h00F900 && cp <= 21'h00FAFF) ||
                    (cp >= 21'h020000 && cp <= 21'h0323AF);
    endfunction

endpackage

// File: design/u8dhc_decode.sv
// Decoder state registers and the per-byte decode and classification logic.
module u8dhc_decode
    import u8dhc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,        // a byte is consumed this cycle
    input  logic [ByteW-1:0] byte_value,
    input  logic             end_of_text,
    output logic             res_valid,   // the byte produces a result
    output res_t             res
);

    logic [CpW-1:0]  partial_reg, partial_next;
    logic [1:0]      remain_reg,  remain_next;
    logic [LenW-1:0] exp_len_reg, exp_len_next;

    logic [CpW-1:0]  shifted;
    logic [1:0]      remain_dec;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            remain_reg  <= '0;
            exp_len_reg <= '0;
        end
        else if (step)
        begin
            partial_reg <= partial_next;
            remain_reg  <= remain_next;
            exp_len_reg <= exp_len_next;
        end
    end

    assign shifted    = {partial_reg[CpW-7:0], byte_value[5:0]};
    assign remain_dec = remain_reg - 2'd1;

    // Next state and result
    always_comb
    begin
        partial_next = '0;
        remain_next  = '0;
        exp_len_next = '0;
        res_valid    = 1'b0;
        res          = '0;
        res.text_done = end_of_text;

        if (remain_reg == 2'd0)
        begin
            // waiting for a lead byte
            if (byte_value <= LeadAsciiMax)
            begin
                res_valid      = 1'b1;
                res.code_point = {{(CpW-ByteW){1'b0}}, byte_value};
                res.seq_length = Len1;
            end
            else if (byte_value >= Lead2Min && byte_value <= Lead2Max)
            begin
                partial_next = {{(CpW-5){1'b0}}, byte_value[4:0]};
                remain_next  = 2'd1;
                exp_len_next = Len2;
            end
            else if (byte_value >= Lead3Min && byte_value <= Lead3Max)
            begin
                partial_next = {{(CpW-4){1'b0}}, byte_value[3:0]};
                remain_next  = 2'd2;
                exp_len_next = Len3;
            end
            else if (byte_value >= Lead4Min && byte_value <= Lead4Max)
            begin
                partial_next = {{(CpW-3){1'b0}}, byte_value[2:0]};
                remain_next  = 2'd3;
                exp_len_next = Len4;
            end
            else
            begin
                res_valid        = 1'b1;
                res.decode_error = 1'b1;
            end

            // text ends right after a multi-byte lead: truncated
            if (!res_valid && end_of_text)
            begin
                partial_next     = '0;
                remain_next      = '0;
                exp_len_next     = '0;
                res_valid        = 1'b1;
                res.decode_error = 1'b1;
            end
        end
        else if (byte_value[7:6] != ContTag)
        begin
            // bad continuation: drop sequence and byte
            res_valid        = 1'b1;
            res.decode_error = 1'b1;
        end
        else if (remain_dec != 2'd0)
        begin
            // more continuation bytes to come
            if (end_of_text)
            begin
                res_valid        = 1'b1;
                res.decode_error = 1'b1;
            end
            else
            begin
                partial_next = shifted;
                remain_next  = remain_dec;
                exp_len_next = exp_len_reg;
            end
        end
        else
        begin
            // last byte: range checks then emit
            res_valid = 1'b1;
            if ((exp_len_reg == Len3 && shifted < Min3Byte) ||
                (exp_len_reg == Len4 && shifted < Min4Byte) ||
                (shifted >= SurrLo && shifted <= SurrHi) ||
                (shifted > MaxScalar))
            begin
                res.decode_error = 1'b1;
            end
            else
            begin
                res.code_point = shifted;
                res.seq_length = exp_len_reg;
                res.is_han     = han_range(shifted);
            end
        end
    end

endmodule

// File: design/u8dhc_out_buf.sv
// Result register with a skid stage towards the output stream.
module u8dhc_out_buf
    import u8dhc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,        // write a result this cycle
    input  res_t push_res,
    output logic room,        // a push is accepted this cycle
    input  logic pop_ready,
    output logic out_valid,
    output res_t out_res
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_reg;
    res_t skid_reg;
    logic pop;

    assign pop       = out_valid_reg && pop_ready;
    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            if (push)
            begin
                out_reg <= push_res;
            end
        end
        else if (push)
        begin
            skid_reg <= push_res;
        end
    end

endmodule

// File: design/utf8_decoder_han_classifier_core.sv
// Top level of the UTF-8 decoder with Han ideograph classification.
//
// Input stream: one UTF-8 byte per beat on s_tdata[7:0]; s_tlast marks the
// final byte of the text. Output stream: at most one beat per input byte,
// carrying the decoded code point and its byte length on m_tdata, the error
// and Han flags on m_tuser, and m_tlast copied from the byte that closed it.
// Bytes in the middle of a good sequence give no output beat.
//
// A byte is held in the input register while it is decoded, and its
// result is registered in the result register, or in the skid stage
// when the receiver stalls. Throughput is one byte per cycle while the skid
// stage is empty; the decoder state is a single short update per byte.
//
// Reset clears the decoder state, the input register and the output
// buffer, so the block waits for a lead byte. When the receiver stalls the
// result register holds, one further result parks in the skid stage, and
// once the input register also holds a byte s_tready drops until the skid
// stage empties.
module utf8_decoder_han_classifier_core
    import u8dhc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // [7:0] byte_value
    input  logic                s_tlast,   // end_of_text
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // [20:0] code_point, [23:21] seq_length
    output logic [OutUserW-1:0] m_tuser,   // [0] decode_error, [1] is_han
    output logic                m_tlast    // text_done
);

    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_eot_reg;

    logic step;
    logic room;
    logic res_valid;
    res_t res;
    res_t out_res;

    assign step     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata[ByteW-1:0];
            in_eot_reg  <= s_tlast;
        end
    end

    // Decode
    u8dhc_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .byte_value  (in_byte_reg),
        .end_of_text (in_eot_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Output buffer
    u8dhc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && res_valid),
        .push_res  (res),
        .room      (room),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.seq_length, out_res.code_point};
    assign m_tuser = {out_res.is_han, out_res.decode_error};
    assign m_tlast = out_res.text_done;

endmodule

// File: verif/tb_utf8_decoder_han_classifier_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 decoder with Han classification.

module tb_utf8_decoder_han_classifier_core
    import u8dhc_pkg::*;
();

    // Lead byte classes seen while no sequence is open
    typedef enum logic [2:0] {
        LeadAscii,
        LeadTwo,
        LeadThree,
        LeadFour,
        LeadInvalid
    } lead_kind_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;     // [7:0] byte_value
    logic                s_tlast = 1'b0;   // end_of_text
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;          // [20:0] code_point, [23:21] seq_length
    logic [OutUserW-1:0] m_tuser;          // [0] decode_error, [1] is_han
    logic                m_tlast;          // text_done

    // Decoder state mirrored on the testbench side
    logic [CpW-1:0]  acc_value = '0;
    logic [1:0]      conts_left = '0;
    logic [LenW-1:0] open_len = '0;

    res_t pending_points[$];
    res_t oldest_point;

    // Bytes of the sequence being built for sending
    logic [ByteW-1:0] enc_bytes [4];
    int               enc_count;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent = 0;
    int mismatch_count = 0;

    utf8_decoder_han_classifier_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Han ideograph blocks: 3007, 3400-4DBF, 4E00-9FFF, F900-FAFF, 20000-323AF
    function automatic logic in_han_block(input logic [CpW-1:0] cp);
        logic hit;
        hit = 1'b0;
        if (cp == 21'h003007)
            hit = 1'b1;
        else if (cp >= 21'h003400 && cp < 21'h004DC0)
            hit = 1'b1;
        else if (cp >= 21'h004E00 && cp < 21'h00A000)
            hit = 1'b1;
        else if (cp >= 21'h00F900 && cp < 21'h00FB00)
            hit = 1'b1;
        else if (cp >= 21'h020000 && cp < 21'h0323B0)
            hit = 1'b1;
        return hit;
    endfunction

    function automatic lead_kind_t classify_lead(input logic [ByteW-1:0] b);
        lead_kind_t kind;
        if (b <= LeadAsciiMax)
            kind = LeadAscii;
        else if (b >= Lead2Min && b <= Lead2Max)
            kind = LeadTwo;
        else if (b >= Lead3Min && b <= Lead3Max)
            kind = LeadThree;
        else if (b >= Lead4Min && b <= Lead4Max)
            kind = LeadFour;
        else
            kind = LeadInvalid;
        return kind;
    endfunction

    // Advance the mirrored decoder by one accepted byte; queue any result
    task automatic track_decoder(input logic [ByteW-1:0] b, input logic last);
        res_t       r;
        logic       fail;
        logic       emit;
        lead_kind_t kind;
        r = '0;
        r.text_done = last;
        fail = 1'b0;
        emit = 1'b0;
        if (conts_left == 2'd0)
        begin
            kind = classify_lead(b);
            case (kind)
                LeadAscii:
                begin
                    acc_value = {13'd0, b};
                    open_len = Len1;
                    emit = 1'b1;
                end
                LeadTwo:
                begin
                    acc_value = {16'd0, b[4:0]};
                    conts_left = 2'd1;
                    open_len = Len2;
                    fail = last;
                end
                LeadThree:
                begin
                    acc_value = {17'd0, b[3:0]};
                    conts_left = 2'd2;
                    open_len = Len3;
                    fail = last;
                end
                LeadFour:
                begin
                    acc_value = {18'd0, b[2:0]};
                    conts_left = 2'd3;
                    open_len = Len4;
                    fail = last;
                end
                default:
                    fail = 1'b1;
            endcase
        end
        else if (b[7:6] != ContTag)
            fail = 1'b1;
        else
        begin
            acc_value = {acc_value[14:0], b[5:0]};
            conts_left = conts_left - 2'd1;
            if (conts_left != 2'd0)
                fail = last;
            else if ((open_len == Len3 && acc_value < Min3Byte) ||
                     (open_len == Len4 && acc_value < Min4Byte) ||
                     (acc_value >= SurrLo && acc_value <= SurrHi) ||
                     acc_value > MaxScalar)
                fail = 1'b1;
            else
                emit = 1'b1;
        end

        if (fail)
        begin
            r.decode_error = 1'b1;
            pending_points.insert(pending_points.size(), r);
        end
        else if (emit)
        begin
            r.code_point = acc_value;
            r.seq_length = open_len;
            r.is_han = in_han_block(acc_value);
            pending_points.insert(pending_points.size(), r);
        end
        if (fail || emit)
        begin
            acc_value = '0;
            conts_left = 2'd0;
            open_len = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Receiver stalls
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Output beat check against the oldest expected result
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_points.size() == 0)
                report_mismatch("beat with no result due, code_point",
                                32'(m_tdata[20:0]), 0);
            else
            begin
                oldest_point = pending_points.pop_front();
                if (m_tdata[20:0] !== oldest_point.code_point)
                    report_mismatch("code_point", 32'(m_tdata[20:0]),
                                    32'(oldest_point.code_point));
                if (m_tdata[23:21] !== oldest_point.seq_length)
                    report_mismatch("seq_length", 32'(m_tdata[23:21]),
                                    32'(oldest_point.seq_length));
                if (m_tuser[0] !== oldest_point.decode_error)
                    report_mismatch("decode_error", 32'(m_tuser[0]),
                                    32'(oldest_point.decode_error));
                if (m_tuser[1] !== oldest_point.is_han)
                    report_mismatch("is_han", 32'(m_tuser[1]), 32'(oldest_point.is_han));
                if (m_tlast !== oldest_point.text_done)
                    report_mismatch("text_done", 32'(m_tlast), 32'(oldest_point.text_done));
            end
        end
    end

    // Send one byte beat; returns at the falling edge after acceptance
    task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'($urandom_range(0, 255));
            s_tlast <= 1'($urandom_range(0, 1));
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_decoder(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Build the n-byte form of v; leads may come out invalid on purpose
    task automatic encode_point(input logic [CpW-1:0] v, input int n);
        enc_count = n;
        case (n)
            1: enc_bytes[0] = v[7:0];
            2:
            begin
                enc_bytes[0] = {3'b110, v[10:6]};
                enc_bytes[1] = {ContTag, v[5:0]};
            end
            3:
            begin
                enc_bytes[0] = {4'b1110, v[15:12]};
                enc_bytes[1] = {ContTag, v[11:6]};
                enc_bytes[2] = {ContTag, v[5:0]};
            end
            default:
            begin
                enc_bytes[0] = {5'b11110, v[20:18]};
                enc_bytes[1] = {ContTag, v[17:12]};
                enc_bytes[2] = {ContTag, v[11:6]};
                enc_bytes[3] = {ContTag, v[5:0]};
            end
        endcase
    endtask

    task automatic send_point(input logic [CpW-1:0] v, input int n, input logic last);
        encode_point(v, n);
        for (int i = 0; i < enc_count; i++)
            send_byte(enc_bytes[i], last && (i == enc_count - 1));
    endtask

    // Random code point and length, weighted towards edges and Han blocks
    task automatic choose_point(output logic [CpW-1:0] v, output int n);
        int cls;
        int sub;
        cls = $urandom_range(0, 99);
        sub = $urandom_range(0, 9);
        if (cls < 15)
        begin
            n = 1;
            v = 21'($urandom_range(0, 8'h7F));
        end
        else if (cls < 30)
        begin
            n = 2;
            v = 21'((sub == 0) ? $urandom_range(0, 8'h7F) : $urandom_range(8'h80, 16'h07FF));
        end
        else if (cls < 62)
        begin
            n = 3;
            case (sub)
                0: v = 21'($urandom_range(0, 16'h07FF));
                1: v = 21'($urandom_range(16'hD7FE, 16'hE001));
                2: v = 21'($urandom_range(16'h33FE, 16'h4DC1));
                3: v = 21'($urandom_range(16'h4DFE, 16'hA001));
                4: v = 21'($urandom_range(16'hF8FE, 16'hFB01));
                5: v = 21'($urandom_range(16'h3006, 16'h3008));
                6: v = ($urandom_range(0, 1) == 1) ? 21'h000800 : 21'h00FFFF;
                default: v = 21'($urandom_range(16'h0800, 16'hFFFF));
            endcase
        end
        else
        begin
            n = 4;
            case (sub)
                0: v = 21'($urandom_range(0, 16'hFFFF));
                1: v = 21'($urandom_range(21'h01FFFE, 21'h0323B1));
                2: v = 21'($urandom_range(21'h10FFFE, 21'h13FFFF));
                3: v = 21'($urandom_range(21'h140000, 21'h1FFFFF));
                4: v = ($urandom_range(0, 1) == 1) ? 21'h010000 : 21'h10FFFF;
                default: v = 21'($urandom_range(21'h010000, 21'h10FFFF));
            endcase
        end
    endtask

    // One well-formed sequence, a broken one, or a noise byte
    task automatic send_random_sequence();
        int             pick;
        int             cut;
        int             idx;
        logic           cut_short;
        logic [CpW-1:0] v;
        int             n;
        logic [7:0]     junk;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        else
        begin
            choose_point(v, n);
            encode_point(v, n);
            cut = enc_count;
            cut_short = 1'b0;
            if (n > 1 && pick >= 86)
            begin
                idx = $urandom_range(1, n - 1);
                if (pick < 93)
                begin
                    // bad continuation: anything but 10xxxxxx
                    junk = 8'($urandom_range(0, 255));
                    if (junk[7:6] == ContTag)
                        junk[6] = 1'b1;
                    enc_bytes[idx] = junk;
                end
                else
                begin
                    // text ends inside the sequence
                    cut = idx;
                    cut_short = 1'b1;
                end
            end
            for (int i = 0; i < cut; i++)
                send_byte(enc_bytes[i], (i == cut - 1) &&
                          (cut_short || $urandom_range(0, 9) == 0));
        end
    endtask

    // Hold the sender off until every queued result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_points.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_single_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(LeadAsciiMax, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'hC1, 1'b0);
        send_byte(8'hF5, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_good_sequences();
        send_point(21'h000080, 2, 1'b0);
        send_point(21'h003007, 3, 1'b0);
        send_point(21'h10FFFF, 4, 1'b1);
    endtask

    task automatic test_malformed();
        send_point(21'h0007FF, 3, 1'b0);    // overlong three-byte form
        send_point(21'h00D800, 3, 1'b0);    // surrogate
        send_point(21'h110000, 4, 1'b0);    // beyond the last scalar
        send_byte(8'hC2, 1'b0);             // lead, then an ASCII byte as a bad continuation
        send_byte(8'h41, 1'b0);
        send_byte(8'hE4, 1'b1);             // text ends on a lead
        send_byte(8'hE4, 1'b0);             // text ends mid-sequence
        send_byte(8'hB8, 1'b1);
    endtask

    task automatic test_random_traffic(input int target_bytes);
        while (bytes_sent < target_bytes)
            send_random_sequence();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 52;
        test_single_bytes();
        test_good_sequences();
        test_malformed();
        test_random_traffic(580);
        drain_results();

        send_idle_pct = 52;
        recv_idle_pct = 28;
        test_random_traffic(1130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(1680);
        drain_results();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
design/u8dhc_pkg.sv
design/u8dhc_decode.sv
design/u8dhc_out_buf.sv
design/utf8_decoder_han_classifier_core.sv
verif/tb_utf8_decoder_han_classifier_core.sv
